/* rtl/median_filter_2d_window_assert.svh */
// Assertion macros used by the filter's window module.
`ifndef MEDIAN_FILTER_2D_WINDOW_ASSERT_SVH
`define MEDIAN_FILTER_2D_WINDOW_ASSERT_SVH

// A property that holds at every clock edge outside reset.
`define MF2D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that implies another in the same cycle.
`define MF2D_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/mf2d_pkg.sv */
`default_nettype none
package mf2d_pkg;
	localparam int PIX_W = 8;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int RAD_W = 3;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_MAX_RADIUS = 7;

	localparam int RST_WIDTH = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_RADIUS = 1;

	localparam int RUN_MAX = 64;
	localparam int BINS = 256;
	localparam int BIN_W = 8;
	localparam int CNT_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_RADIUS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic [BIN_W-1:0] bin;
		logic scan_go;
		logic [CNT_W-1:0] thresh;
	} mf2d_hctl_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic [PIX_W-1:0] median;
	} mf2d_hsts_t;
endpackage
`default_nettype wire

/* rtl/median_filter_2d_window.sv */
// Each accepted item is stored and checked; every window that it completes then takes one
// line store read and one histogram scan to give its median.
// Each result then leaves through the drain, load and hold states, waiting out any stall;
// at most 64 results per item. The frame's final item may complete up to r*W+r+1 results,
// which leave 64 per later item. Reset clears positions, the result queue and the registers
// to 640, 480 and 1, then clears all 256 histogram bins while no item is accepted.
`default_nettype none
`include "median_filter_2d_window_assert.svh"
module median_filter_2d_window #(
	parameter int MAX_WIDTH = mf2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mf2d_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = mf2d_pkg::DEF_MAX_RADIUS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [mf2d_pkg::PIX_W-1:0] pixel,
	output logic out_valid,
	input wire logic out_stall,
	output logic [mf2d_pkg::PIX_W-1:0] median,
	output logic last_of_run,
	output logic end_of_frame,
	input wire logic cfg_we,
	input wire logic [mf2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mf2d_pkg::CFG_W-1:0] cfg_data
);
	import mf2d_pkg::*;

	localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
	localparam int ST_DEPTH = STORE_ROWS * MAX_WIDTH;
	localparam int ST_AW = $clog2(ST_DEPTH);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int SW = $clog2(STORE_ROWS);
	localparam int NW = $clog2(STORE_ROWS + 1);
	localparam int QDEPTH = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1 + RUN_MAX;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);
	localparam int RUNW = $clog2(RUN_MAX + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_WIN = 9'b000000100,
		S_FLUSH = 9'b000001000,
		S_GO = 9'b000010000,
		S_MED = 9'b000100000,
		S_DRAIN = 9'b001000000,
		S_LOAD = 9'b010000000,
		S_HOLD = 9'b100000000
	} state_t;

	state_t state_q;

	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic [RAD_W-1:0] rad_q;

	logic [YW-1:0] irow_q;
	logic [XW-1:0] icol_q;
	logic [SW-1:0] in_slot_q;
	logic [HW-1:0] orow_q;
	logic [XW-1:0] ocol_q;
	logic [SW-1:0] out_slot_q;

	logic [NW-1:0] win_k_q;
	logic [NW-1:0] win_j_q;
	logic signed [HW:0] wy_q;
	logic signed [WW:0] wx_q;
	logic [SW-1:0] wslot_q;
	logic cur_eof_q;
	logic smp_v_s1;

	logic [QAW-1:0] q_head_q;
	logic [QAW-1:0] q_tail_q;
	logic [QCW-1:0] q_count_q;
	logic [RUNW-1:0] run_q;

	logic out_valid_q;
	logic [PIX_W-1:0] med_q;
	logic last_q;
	logic eof_q;

	logic [PIX_W-1:0] st_mem [ST_DEPTH];
	logic [PIX_W-1:0] st_rd_q;
	logic [PIX_W:0] q_mem [QDEPTH];
	logic [PIX_W:0] q_rd_q;

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [RAD_W-1:0] eff_r;
	logic [WW-1:0] wm1;
	logic [HW-1:0] hm1;
	logic [NW-1:0] two_r;
	logic [CNT_W-1:0] thresh;
	logic [HW:0] nr_sum;
	logic [HW-1:0] nr;
	logic [WW:0] nc_sum;
	logic [WW-1:0] nc;
	logic ready_c;
	logic signed [WW:0] wx_start;
	logic signed [HW:0] y_nx;
	logic y_adv;
	logic [XW-1:0] xcl;
	logic in_acc;
	logic [ST_AW-1:0] st_wa;
	logic [ST_AW-1:0] st_ra;
	logic q_we;
	mf2d_hctl_t h_ctl;
	mf2d_hsts_t h_sts;

	always_comb begin
		if (fw_q == '0) begin
			eff_w = WW'(1);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(fw_q);
		end
		if (fh_q == '0) begin
			eff_h = HW'(1);
		end else if (int'(fh_q) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(fh_q);
		end
		if (rad_q == '0) begin
			eff_r = RAD_W'(1);
		end else if (int'(rad_q) > MAX_RADIUS) begin
			eff_r = RAD_W'(MAX_RADIUS);
		end else begin
			eff_r = rad_q;
		end
	end

	assign wm1 = eff_w - WW'(1);
	assign hm1 = eff_h - HW'(1);
	assign two_r = NW'({eff_r, 1'b0});
	assign thresh = CNT_W'(2 * int'(eff_r) * (int'(eff_r) + 1));

	// An output pixel is ready once the lowest, rightmost pixel of its window has arrived.
	assign nr_sum = (HW+1)'(orow_q) + (HW+1)'(eff_r);
	assign nr = (nr_sum > (HW+1)'(hm1)) ? hm1 : nr_sum[HW-1:0];
	assign nc_sum = (WW+1)'(ocol_q) + (WW+1)'(eff_r);
	assign nc = (nc_sum > (WW+1)'(wm1)) ? wm1 : nc_sum[WW-1:0];
	assign ready_c = (orow_q < eff_h) &&
		((nr < HW'(irow_q)) || (nr == HW'(irow_q) && nc <= WW'(icol_q)));

	assign wx_start = (WW+1)'(ocol_q) - (WW+1)'(eff_r);
	assign y_nx = wy_q + (HW+1)'(1);
	assign y_adv = !y_nx[HW] && (y_nx != '0) && (y_nx <= $signed((HW+1)'(hm1)));

	always_comb begin
		if (wx_q[WW]) begin
			xcl = '0;
		end else if (wx_q > $signed((WW+1)'(wm1))) begin
			xcl = XW'(wm1);
		end else begin
			xcl = XW'(wx_q[WW-1:0]);
		end
	end

	assign in_stall = !(state_q == S_IDLE && h_sts.ready);
	assign in_acc = in_valid && !in_stall;
	assign st_wa = ST_AW'(int'(in_slot_q) * MAX_WIDTH + int'(icol_q));
	assign st_ra = ST_AW'(int'(wslot_q) * MAX_WIDTH + int'(xcl));
	assign q_we = (state_q == S_MED) && h_sts.done && (q_count_q < QCW'(QDEPTH));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_mem[st_wa] <= pixel;
		end
		st_rd_q <= st_mem[st_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_tail_q] <= {cur_eof_q, h_sts.median};
		end
		q_rd_q <= q_mem[q_head_q];
	end

	assign h_ctl.valid = smp_v_s1;
	assign h_ctl.bin = st_rd_q;
	assign h_ctl.scan_go = (state_q == S_GO);
	assign h_ctl.thresh = thresh;

	mf2d_hist u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(h_ctl),
		.sts(h_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fw_q <= FW_W'(RST_WIDTH);
			fh_q <= FH_W'(RST_HEIGHT);
			rad_q <= RAD_W'(RST_RADIUS);
			irow_q <= '0;
			icol_q <= '0;
			in_slot_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
			out_slot_q <= '0;
			win_k_q <= '0;
			win_j_q <= '0;
			wy_q <= '0;
			wx_q <= '0;
			wslot_q <= '0;
			cur_eof_q <= 1'b0;
			smp_v_s1 <= 1'b0;
			q_head_q <= '0;
			q_tail_q <= '0;
			q_count_q <= '0;
			run_q <= '0;
			out_valid_q <= 1'b0;
			med_q <= '0;
			last_q <= 1'b0;
			eof_q <= 1'b0;
		end else begin
			smp_v_s1 <= (state_q == S_WIN);
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (ready_c) begin
						win_k_q <= '0;
						win_j_q <= '0;
						wx_q <= wx_start;
						wy_q <= (HW+1)'(orow_q) - (HW+1)'(eff_r);
						if (int'(orow_q) >= int'(eff_r)) begin
							if (int'(out_slot_q) >= int'(eff_r)) begin
								wslot_q <= SW'(int'(out_slot_q) - int'(eff_r));
							end else begin
								wslot_q <= SW'(int'(out_slot_q) + int'(two_r) + 1 - int'(eff_r));
							end
						end else begin
							wslot_q <= '0;
						end
						cur_eof_q <= (orow_q == hm1) && (ocol_q == XW'(wm1));
						state_q <= S_WIN;
					end else begin
						if (icol_q == XW'(wm1)) begin
							icol_q <= '0;
							if (int'(irow_q) == int'(hm1)) begin
								irow_q <= '0;
								in_slot_q <= '0;
								orow_q <= '0;
								ocol_q <= '0;
								out_slot_q <= '0;
							end else begin
								irow_q <= irow_q + YW'(1);
								if (int'(in_slot_q) == int'(two_r)) begin
									in_slot_q <= '0;
								end else begin
									in_slot_q <= in_slot_q + SW'(1);
								end
							end
						end else begin
							icol_q <= icol_q + XW'(1);
						end
						if (q_count_q > QCW'(RUN_MAX)) begin
							run_q <= RUNW'(RUN_MAX);
						end else begin
							run_q <= RUNW'(q_count_q);
						end
						state_q <= (q_count_q != '0) ? S_DRAIN : S_IDLE;
					end
				end
				S_WIN: begin
					if (win_j_q == two_r) begin
						win_j_q <= '0;
						wx_q <= wx_start;
						if (win_k_q == two_r) begin
							state_q <= S_FLUSH;
						end else begin
							win_k_q <= win_k_q + NW'(1);
							wy_q <= y_nx;
							if (y_adv) begin
								if (int'(wslot_q) == int'(two_r)) begin
									wslot_q <= '0;
								end else begin
									wslot_q <= wslot_q + SW'(1);
								end
							end
						end
					end else begin
						win_j_q <= win_j_q + NW'(1);
						wx_q <= wx_q + (WW+1)'(1);
					end
				end
				S_FLUSH: begin
					state_q <= S_GO;
				end
				S_GO: begin
					state_q <= S_MED;
				end
				S_MED: begin
					if (h_sts.done) begin
						if (q_we) begin
							q_tail_q <= (q_tail_q == QAW'(QDEPTH - 1)) ? '0 : q_tail_q + QAW'(1);
							q_count_q <= q_count_q + QCW'(1);
						end
						if (ocol_q == XW'(wm1)) begin
							ocol_q <= '0;
							orow_q <= orow_q + HW'(1);
							if (int'(out_slot_q) == int'(two_r)) begin
								out_slot_q <= '0;
							end else begin
								out_slot_q <= out_slot_q + SW'(1);
							end
						end else begin
							ocol_q <= ocol_q + XW'(1);
						end
						state_q <= S_CHECK;
					end
				end
				S_DRAIN: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					med_q <= q_rd_q[PIX_W-1:0];
					eof_q <= q_rd_q[PIX_W];
					last_q <= (run_q == RUNW'(1));
					out_valid_q <= 1'b1;
					q_head_q <= (q_head_q == QAW'(QDEPTH - 1)) ? '0 : q_head_q + QAW'(1);
					q_count_q <= q_count_q - QCW'(1);
					run_q <= run_q - RUNW'(1);
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= (run_q == '0) ? S_IDLE : S_DRAIN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: begin
						fw_q <= cfg_data[FW_W-1:0];
					end
					CFG_FRAME_HEIGHT: begin
						fh_q <= cfg_data[FH_W-1:0];
					end
					CFG_RADIUS: begin
						rad_q <= cfg_data[RAD_W-1:0];
					end
					default: begin
						fw_q <= fw_q;
					end
				endcase
				if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
					cfg_index == CFG_RADIUS) begin
					irow_q <= '0;
					icol_q <= '0;
					in_slot_q <= '0;
					orow_q <= '0;
					ocol_q <= '0;
					out_slot_q <= '0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign median = med_q;
	assign last_of_run = last_q;
	assign end_of_frame = eof_q;

	`MF2D_ASSERT(a_queue_bound, q_count_q <= QCW'(QDEPTH), "result queue count past its depth")
	`MF2D_IMPLY(a_done_in_med, h_sts.done, state_q == S_MED, "median finished outside wait state")
	`MF2D_IMPLY(a_scan_after_flush, state_q == S_GO, !smp_v_s1, "scan started with samples in flight")
	`MF2D_IMPLY(a_load_nonempty, state_q == S_LOAD, q_count_q != '0, "queue read while empty")
endmodule
`default_nettype wire

/* rtl/mf2d_hist.sv */
`default_nettype none
module mf2d_hist (
	input wire logic clk,
	input wire logic arst_n,
	input wire mf2d_pkg::mf2d_hctl_t ctl,
	output mf2d_pkg::mf2d_hsts_t sts
);
	import mf2d_pkg::*;

	typedef enum logic [2:0] {
		H_CLEAR = 3'b001,
		H_ACC = 3'b010,
		H_SCAN = 3'b100
	} hst_t;

	hst_t st_q;
	logic [CNT_W-1:0] mem [BINS];
	logic [CNT_W-1:0] rd_q;
	logic [BIN_W:0] idx_q;
	logic pv_s2;
	logic [BIN_W-1:0] pb_s2;
	logic wv_q;
	logic [BIN_W-1:0] wb_q;
	logic [CNT_W-1:0] wc_q;
	logic [CNT_W-1:0] sum_q;
	logic [PIX_W-1:0] med_q;
	logic found_q;
	logic done_q;

	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] inc;
	logic [CNT_W-1:0] sum_nx;
	logic [BIN_W-1:0] ra;
	logic we;
	logic [BIN_W-1:0] wa;
	logic [CNT_W-1:0] wd;

	// A bin written in the same cycle as a read of it is not yet visible to that read.
	assign cnt = (wv_q && wb_q == pb_s2) ? wc_q : rd_q;
	assign inc = cnt + CNT_W'(1);
	assign sum_nx = sum_q + rd_q;
	assign ra = (st_q == H_SCAN) ? idx_q[BIN_W-1:0] : ctl.bin;

	always_comb begin
		we = 1'b0;
		wa = pb_s2;
		wd = '0;
		case (st_q)
			H_CLEAR: begin
				we = 1'b1;
				wa = idx_q[BIN_W-1:0];
			end
			H_SCAN: begin
				we = pv_s2;
			end
			H_ACC: begin
				we = pv_s2;
				wd = inc;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_CLEAR;
			idx_q <= '0;
			pv_s2 <= 1'b0;
			pb_s2 <= '0;
			wv_q <= 1'b0;
			wb_q <= '0;
			wc_q <= '0;
			sum_q <= '0;
			med_q <= '0;
			found_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				H_CLEAR: begin
					pv_s2 <= 1'b0;
					wv_q <= 1'b0;
					if (idx_q == (BIN_W+1)'(BINS - 1)) begin
						idx_q <= '0;
						st_q <= H_ACC;
					end else begin
						idx_q <= idx_q + (BIN_W+1)'(1);
					end
				end
				H_ACC: begin
					pv_s2 <= ctl.valid;
					pb_s2 <= ctl.bin;
					wv_q <= pv_s2;
					wb_q <= pb_s2;
					wc_q <= inc;
					if (ctl.scan_go) begin
						st_q <= H_SCAN;
						idx_q <= '0;
						sum_q <= '0;
						found_q <= 1'b0;
					end
				end
				H_SCAN: begin
					wv_q <= 1'b0;
					if (idx_q < (BIN_W+1)'(BINS)) begin
						pv_s2 <= 1'b1;
						pb_s2 <= idx_q[BIN_W-1:0];
						idx_q <= idx_q + (BIN_W+1)'(1);
					end else begin
						pv_s2 <= 1'b0;
					end
					if (pv_s2) begin
						sum_q <= sum_nx;
						if (!found_q && sum_nx > ctl.thresh) begin
							found_q <= 1'b1;
							med_q <= pb_s2;
						end
						if (pb_s2 == BIN_W'(BINS - 1)) begin
							done_q <= 1'b1;
							pv_s2 <= 1'b0;
							st_q <= H_ACC;
						end
					end
				end
				default: begin
					st_q <= H_CLEAR;
				end
			endcase
		end
	end

	assign sts.ready = (st_q == H_ACC);
	assign sts.done = done_q;
	assign sts.median = med_q;
endmodule
`default_nettype wire
